[rtl/core/mted_pkg.sv]
// shared constants, types and register codes of the multi-tap echo delay
`default_nettype none

package mted_pkg;

   // history and sample sizing (history depth is a power of two)
   localparam int HISTORY_DEPTH = 16384;
   localparam int MAX_TAPS      = 15;
   localparam int SAMPLE_BITS   = 16;
   localparam int ADDR_BITS     = $clog2(HISTORY_DEPTH);

   // register field widths
   localparam int DELAY_W   = 14;
   localparam int GAIN_W    = 15;
   localparam int TAPC_W    = 4;
   localparam int FRAC_BITS = 15;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DELAY = 2'd0,
      CSR_GAIN  = 2'd1,
      CSR_TAPS  = 2'd2
   } csr_reg_type;

   // register reset values
   localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(0);
   localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(22938);
   localparam logic [TAPC_W-1:0]  TAPC_RESET  = TAPC_W'(2);

   // shared multiplier and accumulator sizing
   localparam int MUL_A_W = (SAMPLE_BITS > GAIN_W + 1) ? SAMPLE_BITS : GAIN_W + 1;
   localparam int MUL_B_W = GAIN_W + 1;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = PROD_W + $clog2(MAX_TAPS + 1) + 1;
   localparam int RES_W   = ACC_W - FRAC_BITS;

   // tap offset and tap counter sizing
   localparam int OFF_W = ((DELAY_W > ADDR_BITS) ? DELAY_W : ADDR_BITS) + 1;
   localparam int J_W   = $clog2(MAX_TAPS + 2);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [ADDR_BITS-1:0]          addr_type;

endpackage

`default_nettype wire

[rtl/core/mted_ifs.sv]
// valid/ready channel interfaces for sample, result and register transactions
`default_nettype none

interface mted_req_if import mted_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type in_sample;

   modport source (output valid, output in_sample, input ready);
   modport sink   (input valid, input in_sample, output ready);
endinterface

interface mted_rsp_if import mted_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type out_sample;
   logic       clipped;

   modport source (output valid, output out_sample, output clipped, input ready);
   modport sink   (input valid, input out_sample, input clipped, output ready);
endinterface

interface mted_csr_if import mted_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

[rtl/core/mted_hist.sv]
// sample history memory: one write port, one registered read port
`default_nettype none

module mted_hist import mted_pkg::*; (
   input  wire             clock,
   input  wire             wr_en,
   input  wire addr_type   wr_addr,
   input  wire sample_type wr_data,
   input  wire             rd_en,
   input  wire addr_type   rd_addr,
   output sample_type      rd_data
);

   sample_type hist_mem_ff [HISTORY_DEPTH];
   sample_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= hist_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/mted_mult.sv]
// shared signed multiplier with registered product
`default_nettype none

module mted_mult import mted_pkg::*; (
   input  wire                       clock,
   input  wire                       en,
   input  wire signed [MUL_A_W-1:0]  op_a,
   input  wire signed [MUL_B_W-1:0]  op_b,
   output logic signed [PROD_W-1:0]  prod
);

   logic signed [PROD_W-1:0] prod_ff;

   // one product per enabled cycle
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= op_a * op_b;
      end
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

[rtl/core/multi_tap_echo_delay.sv]
// multi-tap feed-forward echo: top level with tap sequencer and output register
// each tap steps through decide, read, multiply, accumulate and power update; a skipped
// tap only advances the gain power; a held result register keeps the sequencer in S_ROUND
// one sample at a time: a new sample is taken only in the idle state, after the last
// result has entered the output register, since one multiplier and one read port serve every tap
// reset: registers to defaults, history treated as zero via a wrap flag, no sweep
`default_nettype none

module multi_tap_echo_delay import mted_pkg::*; (
   input wire         clock,
   input wire         reset,
   mted_req_if.sink   req_ch,
   mted_rsp_if.source rsp_ch,
   mted_csr_if.sink   csr_ch
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_TAP,
      S_MULS,
      S_MACC,
      S_POW,
      S_PUPD,
      S_ROUND
   } state_type;

   state_type state_ff, state_in;

   logic [DELAY_W-1:0] delay_ff, delay_in;
   logic [GAIN_W-1:0]  gain_ff, gain_in;
   logic [TAPC_W-1:0]  tapc_ff, tapc_in;

   addr_type           pos_ff, pos_in;
   logic               wrap_ff, wrap_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [GAIN_W-1:0]  power_ff, power_in;
   logic [OFF_W-1:0]   off_ff, off_in;
   logic [J_W-1:0]     j_ff, j_in;
   logic [J_W-1:0]     taps_ff, taps_in;

   logic               rsp_valid_ff, rsp_valid_in;
   sample_type         out_ff, out_in;
   logic               clip_ff, clip_in;

   // memory and multiplier hookup
   logic                     wr_en;
   logic                     rd_en;
   addr_type                 rd_addr;
   sample_type               rd_data;
   logic                     mul_en;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod;

   // datapath helpers
   logic                       tap_hit;
   logic [PROD_W-1:0]          pw_rnd;
   logic [ACC_W-1:0]           acc_rnd;
   logic [RES_W-1:0]           res;
   logic [RES_W-SAMPLE_BITS:0] res_top;
   logic                       res_ovf;
   logic                       out_free;

   mted_hist u_hist (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pos_ff),
      .wr_data (req_ch.in_sample),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mted_mult u_mult (
      .clock (clock),
      .en    (mul_en),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   // tap address and validity: unwritten slots lie ahead of the first wrap
   assign tap_hit = (off_ff != '0) && (off_ff < OFF_W'(HISTORY_DEPTH)) &&
                    (wrap_ff || (OFF_W'(pos_ff) >= off_ff));
   assign rd_addr = pos_ff - off_ff[ADDR_BITS-1:0];

   // next gain power, rounded to nearest
   assign pw_rnd = $unsigned(prod) + (PROD_W'(1) << (FRAC_BITS - 1));

   // final rounding and saturation check
   assign acc_rnd = acc_ff + (ACC_W'(1) << (FRAC_BITS - 1));
   assign res     = acc_rnd[ACC_W-1:FRAC_BITS];
   assign res_top = res[RES_W-1:SAMPLE_BITS-1];
   assign res_ovf = !((&res_top) || (~|res_top));

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready      = (state_ff == S_IDLE);
   assign csr_ch.ready      = 1'b1;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_sample = out_ff;
   assign rsp_ch.clipped    = clip_ff;

   // sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      delay_in     = delay_ff;
      gain_in      = gain_ff;
      tapc_in      = tapc_ff;
      pos_in       = pos_ff;
      wrap_in      = wrap_ff;
      acc_in       = acc_ff;
      power_in     = power_ff;
      off_in       = off_ff;
      j_in         = j_ff;
      taps_in      = taps_ff;
      rsp_valid_in = rsp_valid_ff;
      out_in       = out_ff;
      clip_in      = clip_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      mul_en       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;

      // result transaction taken
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      // register writes
      if (csr_ch.valid) begin
         case (csr_reg_type'(csr_ch.index))
            CSR_DELAY: delay_in = csr_ch.wdata[DELAY_W-1:0];
            CSR_GAIN:  gain_in  = csr_ch.wdata[GAIN_W-1:0];
            CSR_TAPS:  tapc_in  = csr_ch.wdata[TAPC_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         // store the dry sample and load the accumulator
         S_IDLE: begin
            if (req_ch.valid) begin
               wr_en    = 1'b1;
               acc_in   = {{(ACC_W-SAMPLE_BITS-FRAC_BITS){req_ch.in_sample[SAMPLE_BITS-1]}},
                           req_ch.in_sample, {FRAC_BITS{1'b0}}};
               power_in = gain_ff;
               off_in   = OFF_W'(delay_ff);
               j_in     = J_W'(1);
               taps_in  = (int'(tapc_ff) > MAX_TAPS) ? J_W'(MAX_TAPS) : J_W'(tapc_ff);
               state_in = S_TAP;
            end
         end
         // decide on the next tap
         S_TAP: begin
            if (j_ff > taps_ff) begin
               state_in = S_ROUND;
            end else if (tap_hit) begin
               rd_en    = 1'b1;
               state_in = S_MULS;
            end else begin
               state_in = S_POW;
            end
         end
         // history sample times gain power
         S_MULS: begin
            mul_en   = 1'b1;
            mul_a    = MUL_A_W'(rd_data);
            mul_b    = {1'b0, power_ff};
            state_in = S_MACC;
         end
         // accumulate and start the next gain power
         S_MACC: begin
            acc_in   = acc_ff + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
            mul_en   = 1'b1;
            mul_a    = {{(MUL_A_W-GAIN_W){1'b0}}, power_ff};
            mul_b    = {1'b0, gain_ff};
            state_in = S_PUPD;
         end
         // skipped tap: only the gain power advances
         S_POW: begin
            mul_en   = 1'b1;
            mul_a    = {{(MUL_A_W-GAIN_W){1'b0}}, power_ff};
            mul_b    = {1'b0, gain_ff};
            state_in = S_PUPD;
         end
         // round the power, step tap index and offset
         S_PUPD: begin
            power_in = pw_rnd[FRAC_BITS+GAIN_W-1:FRAC_BITS];
            j_in     = j_ff + J_W'(1);
            if (off_ff < OFF_W'(HISTORY_DEPTH)) begin
               off_in = off_ff + OFF_W'(delay_ff);
            end
            state_in = S_TAP;
         end
         // round, saturate and hand over to the output register
         S_ROUND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               clip_in      = res_ovf;
               if (res_ovf) begin
                  out_in = res[RES_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                        : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
               end else begin
                  out_in = res[SAMPLE_BITS-1:0];
               end
               pos_in = pos_ff + ADDR_BITS'(1);
               if (&pos_ff) begin
                  wrap_in = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         delay_ff     <= DELAY_RESET;
         gain_ff      <= GAIN_RESET;
         tapc_ff      <= TAPC_RESET;
         pos_ff       <= '0;
         wrap_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         delay_ff     <= delay_in;
         gain_ff      <= gain_in;
         tapc_ff      <= tapc_in;
         pos_ff       <= pos_in;
         wrap_ff      <= wrap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff   <= acc_in;
      power_ff <= power_in;
      off_ff   <= off_in;
      j_ff     <= j_in;
      taps_ff  <= taps_in;
      out_ff   <= out_in;
      clip_ff  <= clip_in;
   end

endmodule

`default_nettype wire

[rtl/core/mted_checker.sv]
// port-level checks for the multi-tap echo delay, bound to the top level
`default_nettype none

module mted_checker import mted_pkg::*; (
   input wire             clock,
   input wire             reset,
   input wire             req_valid,
   input wire             req_ready,
   input wire             rsp_valid,
   input wire             rsp_ready,
   input wire sample_type rsp_out_sample,
   input wire             rsp_clipped
);

   localparam sample_type SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam sample_type SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // a stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_sample))
      else $error("result dropped or changed while stalled");

   // the block is busy right after taking a sample
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sample taken while still working");

   // a clipped result sits at a rail
   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |-> rsp_out_sample == SAT_MAX || rsp_out_sample == SAT_MIN)
      else $error("clipped result not at a rail");

   // reset leaves the block idle with no result pending
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind multi_tap_echo_delay mted_checker u_mted_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_out_sample (rsp_ch.out_sample),
   .rsp_clipped    (rsp_ch.clipped)
);

`default_nettype wire

[verif/tb_top.sv]
// self-checking testbench of the multi-tap echo delay: directed table, then random phases
module tb_top;
   import mted_pkg::*;

   localparam int NUM_ROWS        = 25;
   localparam int NUM_PHASES      = 12;
   localparam int ITEMS_PER_PHASE = 111;
   localparam int IDLE_PCT        = 36;
   localparam int HOLD_CYCLES     = 400;
   localparam int TAIL_CYCLES     = 2 + 4 * MAX_TAPS + 8;
   localparam longint SAT_MAX     = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint SAT_MIN     = -SAT_MAX - 1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic {ROW_SAMPLE, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] index;
      logic [15:0]          value;
      int                   reps;
      logic                 pinned;
      sample_type           pin_out;
      logic                 pin_clip;
   } stim_row_type;

   typedef struct packed {
      sample_type out_sample;
      logic       clipped;
   } echo_result_type;

   // directed rows: typed results only where they are plain
   stim_row_type directed_rows [NUM_ROWS] = '{
      '{ROW_SAMPLE, CSR_DELAY,  16'h0000, 1, 1'b1, 16'h0000, 1'b0},
      '{ROW_SAMPLE, CSR_DELAY,  16'h7FFF, 1, 1'b1, 16'h7FFF, 1'b0},
      '{ROW_SAMPLE, CSR_DELAY,  16'h8000, 1, 1'b1, 16'h8000, 1'b0},
      '{ROW_SAMPLE, CSR_DELAY,  16'h0001, 1, 1'b1, 16'h0001, 1'b0},
      '{ROW_SAMPLE, CSR_DELAY,  16'hFFFF, 1, 1'b1, 16'hFFFF, 1'b0},
      '{ROW_CSR,    CSR_TAPS,   16'h000F, 1, 1'b0, 16'h0000, 1'b0},
      '{ROW_CSR,    CSR_DELAY,  16'hC000, 1, 1'b0, 16'h0000, 1'b0},
      '{ROW_SAMPLE, CSR_DELAY,  16'h3039, 1, 1'b1, 16'h3039, 1'b0},
      '{ROW_CSR,    CSR_UNUSED, 16'hFFFF, 1, 1'b0, 16'h0000, 1'b0},
      '{ROW_CSR,    CSR_GAIN,   16'h0000, 1, 1'b0, 16'h0000, 1'b0},
      '{ROW_CSR,    CSR_DELAY,  16'h0001, 1, 1'b0, 16'h0000, 1'b0},
      '{ROW_SAMPLE, CSR_DELAY,  16'hB1E0, 1, 1'b1, 16'hB1E0, 1'b0},
      '{ROW_CSR,    CSR_GAIN,   16'h7FFF, 1, 1'b0, 16'h0000, 1'b0},
      '{ROW_SAMPLE, CSR_DELAY,  16'h7FFF, 3, 1'b0, 16'h0000, 1'b0},
      '{ROW_SAMPLE, CSR_DELAY,  16'h8000, 3, 1'b0, 16'h0000, 1'b0},
      '{ROW_CSR,    CSR_DELAY,  16'h3FFF, 1, 1'b0, 16'h0000, 1'b0},
      '{ROW_CSR,    CSR_TAPS,   16'h0002, 1, 1'b0, 16'h0000, 1'b0},
      '{ROW_CSR,    CSR_GAIN,   16'h599A, 1, 1'b0, 16'h0000, 1'b0},
      '{ROW_SAMPLE, CSR_DELAY,  16'h03E8, 2, 1'b0, 16'h0000, 1'b0},
      '{ROW_CSR,    CSR_DELAY,  16'h2000, 1, 1'b0, 16'h0000, 1'b0},
      '{ROW_SAMPLE, CSR_DELAY,  16'h01F4, 2, 1'b0, 16'h0000, 1'b0},
      '{ROW_CSR,    CSR_DELAY,  16'hFFFF, 1, 1'b0, 16'h0000, 1'b0},
      '{ROW_CSR,    CSR_GAIN,   16'hFFFF, 1, 1'b0, 16'h0000, 1'b0},
      '{ROW_CSR,    CSR_TAPS,   16'hFFFF, 1, 1'b0, 16'h0000, 1'b0},
      '{ROW_SAMPLE, CSR_DELAY,  16'h5555, 2, 1'b0, 16'h0000, 1'b0}
   };

   logic clock;
   logic reset = 1'b1;

   mted_req_if req_if ();
   mted_rsp_if rsp_if ();
   mted_csr_if csr_if ();

   multi_tap_echo_delay dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // clock, period 10
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // shadow of the block: history, write slot and registers
   sample_type         echo_history [HISTORY_DEPTH];
   addr_type           hist_wr_pos = '0;
   logic [DELAY_W-1:0] cfg_delay   = DELAY_RESET;
   logic [GAIN_W-1:0]  cfg_gain    = GAIN_RESET;
   logic [TAPC_W-1:0]  cfg_taps    = TAPC_RESET;

   echo_result_type expected_echo_q [$];
   int              mismatch_count = 0;

   // control shared by the stimulus and the receiver
   bit              idle_on       = 1'b1;
   bit              hold_request  = 1'b0;
   bit              pinned_valid  = 1'b0;
   echo_result_type pinned_result = '0;

   initial begin
      foreach (echo_history[i]) echo_history[i] = '0;
   end

   // store the sample, then mix in the weighted taps with rounding and saturation
   function automatic echo_result_type predict_echo(input sample_type dry);
      echo_result_type r;
      longint          acc;
      longint          gain_pow;
      longint          off;
      longint          res;
      int              taps;
      addr_type        pos;
      addr_type        idx;
      pos = hist_wr_pos;
      echo_history[pos] = dry;
      acc = longint'(dry) * 32768;
      gain_pow = longint'(cfg_gain);
      taps = (int'(cfg_taps) > MAX_TAPS) ? MAX_TAPS : int'(cfg_taps);
      for (int j = 1; j <= taps; j++) begin
         off = longint'(cfg_delay) * j;
         // zero delay and taps past the history add nothing
         if (off != 0 && off < HISTORY_DEPTH) begin
            idx = addr_type'(longint'(pos) - off);
            acc += longint'(echo_history[idx]) * gain_pow;
         end
         gain_pow = (gain_pow * longint'(cfg_gain) + 16384) >>> FRAC_BITS;
      end
      res = (acc + 16384) >>> FRAC_BITS;
      r.clipped = 1'b0;
      if (res > SAT_MAX) begin
         res = SAT_MAX;
         r.clipped = 1'b1;
      end else if (res < SAT_MIN) begin
         res = SAT_MIN;
         r.clipped = 1'b1;
      end
      r.out_sample = sample_type'(res);
      hist_wr_pos = pos + 1'b1;
      return r;
   endfunction

   // monitor: check results, track register writes, predict accepted samples
   always @(posedge clock) begin
      echo_result_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_echo_q.size() == 0) begin
               $error("unexpected result transaction: out_sample %0d clipped %0b",
                      rsp_if.out_sample, rsp_if.clipped);
               mismatch_count++;
            end else begin
               want = expected_echo_q.pop_front();
               if (rsp_if.out_sample !== want.out_sample) begin
                  $error("out_sample: expected %0d, actual %0d",
                         want.out_sample, rsp_if.out_sample);
                  mismatch_count++;
               end
               if (rsp_if.clipped !== want.clipped) begin
                  $error("clipped: expected %0b, actual %0b", want.clipped, rsp_if.clipped);
                  mismatch_count++;
               end
            end
         end
         if (csr_if.valid && csr_if.ready) begin
            if (csr_if.index == CSR_DELAY) cfg_delay = csr_if.wdata[DELAY_W-1:0];
            else if (csr_if.index == CSR_GAIN) cfg_gain = csr_if.wdata[GAIN_W-1:0];
            else if (csr_if.index == CSR_TAPS) cfg_taps = csr_if.wdata[TAPC_W-1:0];
         end
         if (req_if.valid && req_if.ready) begin
            want = predict_echo(req_if.in_sample);
            if (pinned_valid) want = pinned_result;
            expected_echo_q.push_back(want);
         end
      end
   end

   // receiver: random back-pressure, plus one long hold-off on request
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_if.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_if.ready = !(idle_on && $urandom_range(99) < IDLE_PCT);
      end
   end

   // offer one sample transaction, with random gaps in front of it
   task automatic send_sample(input sample_type s);
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_if.valid = 1'b0;
         req_if.in_sample = sample_type'($urandom);
         @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.in_sample = s;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      req_if.valid = 1'b0;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_if.valid = 1'b1;
      csr_if.index = index;
      csr_if.wdata = value;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_echo_q.size() != 0) @(negedge clock);
   endtask

   // tap spacing: mostly short so taps land on written history
   function automatic logic [DELAY_W-1:0] pick_delay();
      case ($urandom_range(9))
         0:       return '0;
         1:       return DELAY_W'($urandom_range(16383, 1501));
         2, 3:    return DELAY_W'($urandom_range(1500, 65));
         default: return DELAY_W'($urandom_range(64, 1));
      endcase
   endfunction

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return GAIN_RESET;
         default: return GAIN_W'($urandom_range(32767, 0));
      endcase
   endfunction

   function automatic sample_type pick_sample();
      case ($urandom_range(9))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2, 3:    return sample_type'($urandom_range(511, 0) - 256);
         default: return sample_type'($urandom);
      endcase
   endfunction

   // stimulus
   initial begin
      req_if.valid = 1'b0;
      req_if.in_sample = '0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_DELAY;
      csr_if.wdata = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      for (int r = 0; r < NUM_ROWS; r++) begin
         if (directed_rows[r].kind == ROW_CSR) begin
            wait_drained();
            write_reg(directed_rows[r].index, directed_rows[r].value);
         end else begin
            for (int k = 0; k < directed_rows[r].reps; k++) begin
               pinned_valid = directed_rows[r].pinned;
               pinned_result.out_sample = directed_rows[r].pin_out;
               pinned_result.clipped = directed_rows[r].pin_clip;
               send_sample(sample_type'(directed_rows[r].value));
               pinned_valid = 1'b0;
            end
         end
      end

      // random phases, each under its own register setting
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_drained();
         req_if.valid = 1'b0;
         case (ph)
            0: begin
               write_reg(CSR_DELAY, {2'($urandom), DELAY_W'(16383)});
               write_reg(CSR_GAIN, {1'($urandom), GAIN_W'(32767)});
               write_reg(CSR_TAPS, {12'($urandom), TAPC_W'(15)});
            end
            1: begin
               write_reg(CSR_DELAY, {2'($urandom), DELAY_W'(0)});
               write_reg(CSR_GAIN, {1'($urandom), GAIN_W'(0)});
               write_reg(CSR_TAPS, {12'($urandom), TAPC_W'(0)});
            end
            3: begin
               write_reg(CSR_DELAY, {2'($urandom), DELAY_W'(1)});
               write_reg(CSR_GAIN, {1'($urandom), GAIN_W'(32767)});
               write_reg(CSR_TAPS, {12'($urandom), TAPC_W'(15)});
            end
            default: begin
               write_reg(CSR_DELAY, {2'($urandom), pick_delay()});
               write_reg(CSR_GAIN, {1'($urandom), pick_gain()});
               write_reg(CSR_TAPS, {12'($urandom), TAPC_W'($urandom_range(15, 1))});
            end
         endcase
         // long receiver hold-off so the block backs up into its input
         if (ph == 2) hold_request = 1'b1;
         idle_on = (ph != 4);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_sample(pick_sample());
            // in phase 6 the sender pauses after every eighth sample until every result is back
            if (ph == 6 && n % 8 == 7) begin
               req_if.valid = 1'b0;
               wait_drained();
            end
         end
      end
      req_if.valid = 1'b0;
      idle_on = 1'b1;

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #8000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/mted_pkg.sv
rtl/core/mted_ifs.sv
rtl/core/mted_hist.sv
rtl/core/mted_mult.sv
rtl/core/multi_tap_echo_delay.sv
rtl/core/mted_checker.sv
verif/tb_top.sv
